### rtl/glb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glb_pkg
// Shared types and codes for the glyph lookup and text bounds block.
// ----------------------------------------------------------------------------
package glb_pkg;

    localparam int CP_W      = 21;
    localparam int COUNT_W   = 9;
    localparam int INDEX_W   = 10;
    localparam int OFFSET_W  = 10;
    localparam int COORD_W   = 16;
    localparam int CFG_IDX_W = 1;

    // input item command codes
    localparam logic [2:0] CMD_LOAD_INTERVAL = 3'd0;
    localparam logic [2:0] CMD_LOAD_GLYPH    = 3'd1;
    localparam logic [2:0] CMD_BEGIN         = 3'd2;
    localparam logic [2:0] CMD_CODE_POINT    = 3'd3;
    localparam logic [2:0] CMD_FINISH        = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_CODE = 1'd1;

    localparam logic [CP_W-1:0] REPLACEMENT_RESET = 21'd65533;

    typedef struct packed {
        logic [CP_W-1:0]     first;
        logic [CP_W-1:0]     last;
        logic [OFFSET_W-1:0] offset;
    } interval_t;

    typedef struct packed {
        logic [7:0]        width;
        logic [7:0]        height;
        logic signed [7:0] left;
        logic signed [7:0] top;
        logic [9:0]        advance;
    } glyph_t;

    // controller to datapath
    typedef struct packed {
        logic latch_item;
        logic write_interval;
        logic write_glyph;
        logic begin_string;
        logic emit_result;
        logic search_init;
        logic use_replacement;
        logic probe_read;
        logic probe_update;
        logic final_read;
        logic glyph_read;
        logic box_update;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] command;
        logic       cp_zero;
        logic       len_zero;
        logic       lo_zero;
        logic       iv_hit;
    } dp_status_t;

endpackage

### rtl/glb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glb_ctrl
// Sequencer for loads, string begin/finish and the binary search lookup.
// ----------------------------------------------------------------------------
module glb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  glb_pkg::dp_status_t sts,
    output glb_pkg::ctrl_cmd_t  cmd
);
    import glb_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_PROBE   = 3'd2;
    localparam logic [2:0] ST_COMPARE = 3'd3;
    localparam logic [2:0] ST_CHECK   = 3'd4;
    localparam logic [2:0] ST_UPDATE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       retry_reg, retry_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        retry_next = retry_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                case (sts.command)
                    CMD_LOAD_INTERVAL: cmd.write_interval = 1'b1;
                    CMD_LOAD_GLYPH:    cmd.write_glyph    = 1'b1;
                    CMD_BEGIN:         cmd.begin_string   = 1'b1;
                    CMD_FINISH:        cmd.emit_result    = 1'b1;
                    CMD_CODE_POINT:
                    begin
                        if (!sts.cp_zero)
                        begin
                            cmd.search_init = 1'b1;
                            retry_next      = 1'b0;
                            state_next      = ST_PROBE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_PROBE:
            begin
                if (!sts.len_zero)
                begin
                    cmd.probe_read = 1'b1;
                    state_next     = ST_COMPARE;
                end
                else if (!sts.lo_zero)
                begin
                    cmd.final_read = 1'b1;
                    state_next     = ST_CHECK;
                end
                else if (!retry_reg)
                begin
                    // miss: search again for the replacement glyph
                    cmd.search_init     = 1'b1;
                    cmd.use_replacement = 1'b1;
                    retry_next          = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMPARE:
            begin
                cmd.probe_update = 1'b1;
                state_next       = ST_PROBE;
            end
            ST_CHECK:
            begin
                if (sts.iv_hit)
                begin
                    cmd.glyph_read = 1'b1;
                    state_next     = ST_UPDATE;
                end
                else if (!retry_reg)
                begin
                    cmd.search_init     = 1'b1;
                    cmd.use_replacement = 1'b1;
                    retry_next          = 1'b1;
                    state_next          = ST_PROBE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPDATE:
            begin
                cmd.box_update = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            retry_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            retry_reg <= retry_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/glb_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glb_dpath
// Interval and glyph memories, search registers, cursor and box arithmetic.
// ----------------------------------------------------------------------------
module glb_dpath #(
    parameter int MAX_INTERVALS = 256,
    parameter int MAX_GLYPHS    = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  glb_pkg::ctrl_cmd_t                cmd,
    output glb_pkg::dp_status_t               sts,
    input  logic                              cfg_we,
    input  logic [glb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [glb_pkg::CP_W-1:0]          cfg_data,
    input  logic [2:0]                        command,
    input  logic [glb_pkg::INDEX_W-1:0]       entry_index,
    input  logic [glb_pkg::CP_W-1:0]          code_point,
    input  logic [glb_pkg::CP_W-1:0]          interval_last,
    input  logic [glb_pkg::OFFSET_W-1:0]      glyph_offset,
    input  logic [7:0]                        glyph_width,
    input  logic [7:0]                        glyph_height,
    input  logic signed [7:0]                 glyph_left,
    input  logic signed [7:0]                 glyph_top,
    input  logic [9:0]                        glyph_advance,
    input  logic signed [glb_pkg::COORD_W-1:0] start_x,
    input  logic signed [glb_pkg::COORD_W-1:0] start_y,
    output logic                              done,
    output logic signed [glb_pkg::COORD_W-1:0] min_x,
    output logic signed [glb_pkg::COORD_W-1:0] min_y,
    output logic signed [glb_pkg::COORD_W-1:0] max_x,
    output logic signed [glb_pkg::COORD_W-1:0] max_y,
    output logic [glb_pkg::COORD_W-1:0]       text_width,
    output logic [glb_pkg::COORD_W-1:0]       text_height,
    output logic                              printable
);
    import glb_pkg::*;

    localparam int LEN_W = $clog2(MAX_INTERVALS + 1);
    localparam int IA_W  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int GA_W  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int GI_W  = CP_W + 1;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 18'sd32767)
            r = 16'sh7fff;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    // configuration
    logic [COUNT_W-1:0] count_reg;
    logic [CP_W-1:0]    repl_reg;

    // latched input item
    logic [2:0]                command_reg;
    logic [INDEX_W-1:0]        index_reg;
    logic [CP_W-1:0]           cp_reg;
    interval_t                 iv_in_reg;
    glyph_t                    gl_in_reg;
    logic signed [COORD_W-1:0] start_x_reg, start_y_reg;

    // search state
    logic [CP_W-1:0]  key_reg;
    logic [LEN_W-1:0] lo_reg, len_reg, mid_reg;
    logic [LEN_W-1:0] half, count_eff;

    // memories
    interval_t iv_mem [MAX_INTERVALS];
    glyph_t    gl_mem [MAX_GLYPHS];
    interval_t iv_rd_reg;
    glyph_t    gl_rd_reg;
    logic [IA_W-1:0] iv_rd_addr;

    logic [GI_W-1:0] gidx;
    logic [CP_W-1:0] diff;

    // box and cursor
    logic signed [COORD_W-1:0] cursor_x_reg, baseline_y_reg;
    logic signed [COORD_W-1:0] box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    logic signed [COORD_W-1:0] lft, rgt, bot, top, adv;
    logic signed [17:0]        cx, by;

    // outputs
    logic                      done_reg;
    logic signed [COORD_W-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic [COORD_W-1:0]        width_reg, height_reg;
    logic                      printable_reg;
    logic [COORD_W-1:0]        w_calc, h_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            repl_reg  <= REPLACEMENT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL_COUNT:   count_reg <= cfg_data[COUNT_W-1:0];
                CFG_REPLACEMENT_CODE: repl_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            command_reg      <= command;
            index_reg        <= entry_index;
            cp_reg           <= code_point;
            iv_in_reg.first  <= code_point;
            iv_in_reg.last   <= interval_last;
            iv_in_reg.offset <= glyph_offset;
            gl_in_reg.width  <= glyph_width;
            gl_in_reg.height <= glyph_height;
            gl_in_reg.left   <= glyph_left;
            gl_in_reg.top    <= glyph_top;
            gl_in_reg.advance <= glyph_advance;
            start_x_reg      <= start_x;
            start_y_reg      <= start_y;
        end
    end

    // counts above the table depth act as the table depth
    assign count_eff = (int'(count_reg) > MAX_INTERVALS) ? LEN_W'(MAX_INTERVALS)
                                                          : LEN_W'(count_reg);
    assign half = len_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            lo_reg  <= '0;
            len_reg <= '0;
            mid_reg <= '0;
        end
        else if (cmd.search_init)
        begin
            key_reg <= cmd.use_replacement ? repl_reg : cp_reg;
            lo_reg  <= '0;
            len_reg <= count_eff;
        end
        else if (cmd.probe_read)
        begin
            mid_reg <= lo_reg + half;
        end
        else if (cmd.probe_update)
        begin
            if (key_reg < iv_rd_reg.first)
            begin
                len_reg <= half;
            end
            else
            begin
                lo_reg  <= mid_reg + LEN_W'(1);
                len_reg <= len_reg - half - LEN_W'(1);
            end
        end
    end

    assign iv_rd_addr = cmd.probe_read ? IA_W'(lo_reg + half) : IA_W'(lo_reg - LEN_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.write_interval && (int'(index_reg) < MAX_INTERVALS))
            iv_mem[IA_W'(index_reg)] <= iv_in_reg;
        if (cmd.probe_read || cmd.final_read)
            iv_rd_reg <= iv_mem[iv_rd_addr];
    end

    // the selected interval was probed with key at or above its first
    assign diff = key_reg - iv_rd_reg.first;
    assign gidx = GI_W'(iv_rd_reg.offset) + GI_W'(diff);

    always_ff @(posedge clk)
    begin
        if (cmd.write_glyph && (int'(index_reg) < MAX_GLYPHS))
            gl_mem[GA_W'(index_reg)] <= gl_in_reg;
        if (cmd.glyph_read)
            gl_rd_reg <= gl_mem[GA_W'(gidx)];
    end

    assign sts.command  = command_reg;
    assign sts.cp_zero  = (cp_reg == '0);
    assign sts.len_zero = (len_reg == '0);
    assign sts.lo_zero  = (lo_reg == '0);
    assign sts.iv_hit   = (key_reg <= iv_rd_reg.last) && (int'(gidx) < MAX_GLYPHS);

    assign cx  = 18'(cursor_x_reg);
    assign by  = 18'(baseline_y_reg);
    assign lft = sat16(cx + 18'(gl_rd_reg.left));
    assign rgt = sat16(cx + 18'(gl_rd_reg.left) + $signed({10'b0, gl_rd_reg.width}));
    assign bot = sat16(by + 18'(gl_rd_reg.top) - $signed({10'b0, gl_rd_reg.height}));
    assign top = sat16(by + 18'(gl_rd_reg.top));
    assign adv = sat16(cx + $signed({8'b0, gl_rd_reg.advance}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            baseline_y_reg <= '0;
            box_min_x_reg  <= '0;
            box_min_y_reg  <= '0;
            box_max_x_reg  <= '0;
            box_max_y_reg  <= '0;
        end
        else if (cmd.begin_string)
        begin
            cursor_x_reg   <= start_x_reg;
            baseline_y_reg <= start_y_reg;
            box_min_x_reg  <= start_x_reg;
            box_max_x_reg  <= start_x_reg;
            box_min_y_reg  <= start_y_reg;
            box_max_y_reg  <= start_y_reg;
        end
        else if (cmd.box_update)
        begin
            if (lft < box_min_x_reg) box_min_x_reg <= lft;
            if (rgt > box_max_x_reg) box_max_x_reg <= rgt;
            if (bot < box_min_y_reg) box_min_y_reg <= bot;
            if (top > box_max_y_reg) box_max_y_reg <= top;
            cursor_x_reg <= adv;
        end
    end

    assign w_calc = box_max_x_reg - box_min_x_reg;
    assign h_calc = box_max_y_reg - box_min_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit_result;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_result)
        begin
            min_x_reg     <= box_min_x_reg;
            min_y_reg     <= box_min_y_reg;
            max_x_reg     <= box_max_x_reg;
            max_y_reg     <= box_max_y_reg;
            width_reg     <= w_calc;
            height_reg    <= h_calc;
            printable_reg <= (w_calc != '0) || (h_calc != '0);
        end
    end

    assign done        = done_reg;
    assign min_x       = min_x_reg;
    assign min_y       = min_y_reg;
    assign max_x       = max_x_reg;
    assign max_y       = max_y_reg;
    assign text_width  = width_reg;
    assign text_height = height_reg;
    assign printable   = printable_reg;

endmodule

### rtl/glyph_lookup_text_bounds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_lookup_text_bounds
// Code point to glyph lookup over a sorted interval table, and bounding box
// measurement of a string of glyphs.
//
//   channel   handshake                 payload
//   --------  ------------------------  --------------------------------------
//   item in   start / busy              command, entry_index, code_point, ...
//   result    done (one-cycle strobe)   min_x .. max_y, text_width/height,
//                                       printable
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An item is taken when start is high and busy is low. Loads, begin and
// unknown commands return to idle after decode; finish raises done after
// decode. A code point runs a binary search of up to clog2(interval_count)+1
// probes on the single interval memory read port; a miss runs a second
// search for the replacement code. Reset clears the box, cursor and interval
// count and sets the replacement code to 65533; tables hold no reset value.
// The result cannot be stalled; config writes are always ready.
// ----------------------------------------------------------------------------
module glyph_lookup_text_bounds #(
    parameter int MAX_INTERVALS = 256,
    parameter int MAX_GLYPHS    = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         command,
    input  logic [glb_pkg::INDEX_W-1:0]        entry_index,
    input  logic [glb_pkg::CP_W-1:0]           code_point,
    input  logic [glb_pkg::CP_W-1:0]           interval_last,
    input  logic [glb_pkg::OFFSET_W-1:0]       glyph_offset,
    input  logic [7:0]                         glyph_width,
    input  logic [7:0]                         glyph_height,
    input  logic signed [7:0]                  glyph_left,
    input  logic signed [7:0]                  glyph_top,
    input  logic [9:0]                         glyph_advance,
    input  logic signed [glb_pkg::COORD_W-1:0] start_x,
    input  logic signed [glb_pkg::COORD_W-1:0] start_y,
    output logic                               done,
    output logic signed [glb_pkg::COORD_W-1:0] min_x,
    output logic signed [glb_pkg::COORD_W-1:0] min_y,
    output logic signed [glb_pkg::COORD_W-1:0] max_x,
    output logic signed [glb_pkg::COORD_W-1:0] max_y,
    output logic [glb_pkg::COORD_W-1:0]        text_width,
    output logic [glb_pkg::COORD_W-1:0]        text_height,
    output logic                               printable,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [glb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [glb_pkg::CP_W-1:0]           cfg_data
);
    import glb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign cfg_ready = 1'b1;

    glb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    glb_dpath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .MAX_GLYPHS    (MAX_GLYPHS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .entry_index   (entry_index),
        .code_point    (code_point),
        .interval_last (interval_last),
        .glyph_offset  (glyph_offset),
        .glyph_width   (glyph_width),
        .glyph_height  (glyph_height),
        .glyph_left    (glyph_left),
        .glyph_top     (glyph_top),
        .glyph_advance (glyph_advance),
        .start_x       (start_x),
        .start_y       (start_y),
        .done          (done),
        .min_x         (min_x),
        .min_y         (min_y),
        .max_x         (max_x),
        .max_y         (max_y),
        .text_width    (text_width),
        .text_height   (text_height),
        .printable     (printable)
    );

endmodule
